// ----- src/nsa_pkg.sv -----
// nsa_pkg: shared types, constants and the arctangent table for the
// normal slope angle block; no dependencies
`default_nettype none
package nsa_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int PRESCALE = 20;
	localparam int FRAC = 16;
	localparam int XY_W = 40;
	localparam int Z_W = 25;
	localparam int TAB_W = 23;
	localparam int MAG_W = 7;

	localparam logic [1:0] SEL_CORDIC = 2'd0;
	localparam logic [1:0] SEL_ZERO = 2'd1;
	localparam logic [1:0] SEL_NINETY = 2'd2;
	localparam logic [1:0] SEL_FORTYFIVE = 2'd3;

	localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(90) <<< FRAC;
	localparam logic [MAG_W-1:0] MAG_NINETY = MAG_W'(90);
	localparam logic [MAG_W-1:0] MAG_FORTYFIVE = MAG_W'(45);

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
	} cord_t;

	typedef struct packed {
		logic [1:0] sel;
		logic neg;
		logic ang_ok;
		logic last;
	} side_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [TAB_W-1:0] atan_q16(input int i);
		logic [TAB_W-1:0] r;
		case (i)
			0: r = TAB_W'(2949120);
			1: r = TAB_W'(1740967);
			2: r = TAB_W'(919879);
			3: r = TAB_W'(466945);
			4: r = TAB_W'(234379);
			5: r = TAB_W'(117304);
			6: r = TAB_W'(58666);
			7: r = TAB_W'(29335);
			8: r = TAB_W'(14668);
			9: r = TAB_W'(7334);
			10: r = TAB_W'(3667);
			11: r = TAB_W'(1833);
			12: r = TAB_W'(917);
			13: r = TAB_W'(458);
			14: r = TAB_W'(229);
			15: r = TAB_W'(115);
			16: r = TAB_W'(57);
			17: r = TAB_W'(29);
			18: r = TAB_W'(14);
			19: r = TAB_W'(7);
			20: r = TAB_W'(4);
			21: r = TAB_W'(2);
			22: r = TAB_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/nsa_cell.sv -----
// nsa_cell: one vectoring cordic rotation with fixed shift STAGE
// depends on nsa_pkg
`default_nettype none
module nsa_cell #(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_vld,
	input wire nsa_pkg::cord_t in_d,
	input wire nsa_pkg::side_t in_sd,
	output logic out_vld,
	output nsa_pkg::cord_t out_d,
	output nsa_pkg::side_t out_sd
);

	localparam logic signed [nsa_pkg::Z_W-1:0] ANG =
		nsa_pkg::Z_W'(nsa_pkg::atan_q16(STAGE));

	logic signed [nsa_pkg::XY_W-1:0] xs;
	logic signed [nsa_pkg::XY_W-1:0] ys;
	nsa_pkg::cord_t nxt;

	always_comb begin
		xs = in_d.x >>> STAGE;
		ys = in_d.y >>> STAGE;
		if (in_d.y > $signed(nsa_pkg::XY_W'(0))) begin
			nxt.x = in_d.x + ys;
			nxt.y = in_d.y - xs;
			nxt.z = in_d.z + ANG;
		end else begin
			nxt.x = in_d.x - ys;
			nxt.y = in_d.y + xs;
			nxt.z = in_d.z - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_d <= nxt;
		out_sd <= in_sd;
	end

endmodule
`default_nettype wire

// ----- src/nsa_out.sv -----
// nsa_out: output stage, clamps the cordic angle, applies special cases and sign
// depends on nsa_pkg
`default_nettype none
module nsa_out (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_vld,
	input wire nsa_pkg::cord_t in_d,
	input wire nsa_pkg::side_t in_sd,
	output logic done,
	output logic signed [7:0] angle_deg,
	output logic angle_valid,
	output logic last_out
);

	logic [nsa_pkg::MAG_W-1:0] cmag;
	logic [nsa_pkg::MAG_W-1:0] mag;
	logic [7:0] deg;

	always_comb begin
		if (in_d.z < $signed(nsa_pkg::Z_W'(0))) begin
			cmag = '0;
		end else if (in_d.z > nsa_pkg::Z_MAX) begin
			cmag = nsa_pkg::MAG_NINETY;
		end else begin
			cmag = in_d.z[nsa_pkg::FRAC +: nsa_pkg::MAG_W];
		end
		case (in_sd.sel)
			nsa_pkg::SEL_CORDIC: mag = cmag;
			nsa_pkg::SEL_ZERO: mag = '0;
			nsa_pkg::SEL_NINETY: mag = nsa_pkg::MAG_NINETY;
			nsa_pkg::SEL_FORTYFIVE: mag = nsa_pkg::MAG_FORTYFIVE;
			default: mag = '0;
		endcase
		deg = in_sd.neg ? 8'(-{1'b0, mag}) : {1'b0, mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		angle_deg <= $signed(deg);
		angle_valid <= in_sd.ang_ok;
		last_out <= in_sd.last;
	end

endmodule
`default_nettype wire

// ----- src/normal_slope_angle_degrees.sv -----
// normal_slope_angle_degrees: top level, input stage, chain of cordic cells
// and output stage; depends on nsa_pkg, nsa_cell, nsa_out
//
// usage:
//  - an item (norm_x, norm_y, last_in) transfers at a rising edge with
//    start high and busy low; busy is always low, so one item can transfer
//    every cycle
//  - each result (angle_deg, angle_valid, last_out) is on the ports for one
//    cycle with done high; results come out in input order
//  - each item passes through one input register, one cell per cordic rotation
//    and one output register, in that order
//  - throughput is one item per cycle; each cell holds one item in flight
//  - angle_deg is atan(y/x) in whole degrees truncated toward zero, -90..90;
//    angle_valid is low and angle_deg zero when both components are zero
//  - reset clears all in-flight items; no result follows reset until new
//    items are started
//  - the receiver cannot stall; results must be taken as they appear
`default_nettype none
module normal_slope_angle_degrees #(
	parameter int CORDIC_STAGES = nsa_pkg::CORDIC_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [15:0] norm_x,
	input wire logic signed [15:0] norm_y,
	input wire logic last_in,
	output logic done,
	output logic signed [7:0] angle_deg,
	output logic angle_valid,
	output logic last_out
);

	localparam int LATENCY = CORDIC_STAGES + 2;

	logic [15:0] ax;
	logic [15:0] ay;
	nsa_pkg::side_t sd_in;

	logic vld_c [0:CORDIC_STAGES];
	nsa_pkg::cord_t d_c [0:CORDIC_STAGES];
	nsa_pkg::side_t sd_c [0:CORDIC_STAGES];

	assign busy = 1'b0;

	always_comb begin
		ax = norm_x[15] ? 16'(-norm_x) : norm_x;
		ay = norm_y[15] ? 16'(-norm_y) : norm_y;
		sd_in.neg = norm_x[15] ^ norm_y[15];
		sd_in.ang_ok = (ax != '0) || (ay != '0);
		sd_in.last = last_in;
		if (ay == '0) begin
			sd_in.sel = nsa_pkg::SEL_ZERO;
		end else if (ax == '0) begin
			sd_in.sel = nsa_pkg::SEL_NINETY;
		end else if (ax == ay) begin
			sd_in.sel = nsa_pkg::SEL_FORTYFIVE;
		end else begin
			sd_in.sel = nsa_pkg::SEL_CORDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else begin
			vld_c[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		d_c[0].x <= $signed({4'b0, ax, nsa_pkg::PRESCALE'(0)});
		d_c[0].y <= $signed({4'b0, ay, nsa_pkg::PRESCALE'(0)});
		d_c[0].z <= '0;
		sd_c[0] <= sd_in;
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		nsa_cell #(
			.STAGE(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_vld(vld_c[g]),
			.in_d(d_c[g]),
			.in_sd(sd_c[g]),
			.out_vld(vld_c[g+1]),
			.out_d(d_c[g+1]),
			.out_sd(sd_c[g+1])
		);
	end

	nsa_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_c[CORDIC_STAGES]),
		.in_d(d_c[CORDIC_STAGES]),
		.in_sd(sd_c[CORDIC_STAGES]),
		.done(done),
		.angle_deg(angle_deg),
		.angle_valid(angle_valid),
		.last_out(last_out)
	);

	a_done_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching transfer");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_deg >= -8'sd90 && angle_deg <= 8'sd90))
		else $error("angle out of range");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !angle_valid) |-> (angle_deg == 8'sd0))
		else $error("invalid normal with nonzero angle");

	a_last_passes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, LATENCY)))
		else $error("last marker mismatch");

endmodule
`default_nettype wire
